// File: rtl/core/fuzzy_set_merge_ops_core_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef FUZZY_SET_MERGE_OPS_CORE_MACROS_SVH
`define FUZZY_SET_MERGE_OPS_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FSMO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define FSMO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/fsmo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsmo_pkg;

    localparam int SET_DEPTH = 32;
    localparam int KEY_BITS  = 16;
    localparam int GRADE_W   = 16;
    localparam int PORT_KEY_W = 16;
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);
    localparam int IDX_W     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int PROD_W    = 2 * GRADE_W;
    localparam int FRAC_W    = 15;

    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [GRADE_W-1:0]    t_grade;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [IDX_W-1:0]      t_idx;

    localparam t_grade GRADE_ONE = t_grade'(32768);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(16384);

    // One stored pair of a set.
    typedef struct packed {
        t_key   key;
        t_grade grade;
    } t_entry;

    typedef enum logic [1:0] {
        FUNC_LOAD_A = 2'd0,
        FUNC_LOAD_B = 2'd1,
        FUNC_RUN    = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    // Register codes of set_op; the codes above complement act as union.
    localparam logic [2:0] SET_OP_UNION = 3'd0;
    localparam logic [2:0] SET_OP_INTER = 3'd1;
    localparam logic [2:0] SET_OP_PSUM  = 3'd2;
    localparam logic [2:0] SET_OP_PROD  = 3'd3;
    localparam logic [2:0] SET_OP_COMPL = 3'd4;

    typedef enum logic [2:0] {
        ALU_PASS_A,
        ALU_PASS_B,
        ALU_MAX,
        ALU_MIN,
        ALU_PSUM,
        ALU_PROD,
        ALU_COMPL
    } t_alu_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CMP,
        ST_MUL,
        ST_COMB,
        ST_FIN
    } t_state;

    // Mask an input key to KEY_BITS bits.
    function automatic t_key key_from_port(input logic [PORT_KEY_W-1:0] k);
        t_key r;
        r = '0;
        for (int i = 0; i < KEY_BITS; i++) begin
            if (i < PORT_KEY_W) r[i] = k[i];
        end
        return r;
    endfunction

    // Mask a stored key to the width of the result port.
    function automatic logic [PORT_KEY_W-1:0] key_to_port(input t_key k);
        logic [PORT_KEY_W-1:0] r;
        r = '0;
        for (int i = 0; i < PORT_KEY_W; i++) begin
            if (i < KEY_BITS) r[i] = k[i];
        end
        return r;
    endfunction

    // Saturate a loaded grade at one.
    function automatic t_grade sat_grade(input t_grade g);
        return (g > GRADE_ONE) ? GRADE_ONE : g;
    endfunction

    // Combining operation for a key present in both sets.
    function automatic t_alu_op alu_for_op(input logic [2:0] op);
        t_alu_op r;
        unique case (op)
            SET_OP_INTER: r = ALU_MIN;
            SET_OP_PSUM:  r = ALU_PSUM;
            SET_OP_PROD:  r = ALU_PROD;
            default:      r = ALU_MAX;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/fsmo_set_store.sv
`timescale 1ns / 1ps
`default_nettype none

module fsmo_set_store
    import fsmo_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_we,
    input  wire t_idx   i_waddr,
    input  wire t_entry i_wdata,
    input  wire t_idx   i_raddr,
    output t_entry      o_rdata
);

    t_entry r_mem [SET_DEPTH];
    t_entry r_rdata;

    // Write one pair per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read of the head entry.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/fsmo_grade_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module fsmo_grade_alu
    import fsmo_pkg::*;
(
    input  wire logic    i_clk,
    input  wire t_grade  i_a,
    input  wire t_grade  i_b,
    input  wire t_alu_op i_op,
    output t_grade       o_grade
);

    logic [PROD_W-1:0]  r_prod;
    logic [PROD_W-1:0]  rounded;
    t_grade             ab;
    logic [GRADE_W+1:0] psum_raw;
    t_grade             psum;

    // Register the raw product ahead of rounding.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    // Round half up and scale back to Q1.15.
    always_comb begin
        rounded = r_prod + ROUND_HALF;
        ab      = rounded[FRAC_W+GRADE_W-1:FRAC_W];
    end

    // a + b - ab, saturated at one.
    always_comb begin
        psum_raw = {2'b00, i_a} + {2'b00, i_b} - {2'b00, ab};
        psum     = (psum_raw > {2'b00, GRADE_ONE}) ? GRADE_ONE : psum_raw[GRADE_W-1:0];
    end

    always_comb begin
        unique case (i_op)
            ALU_PASS_A: o_grade = i_a;
            ALU_PASS_B: o_grade = i_b;
            ALU_MAX:    o_grade = (i_a > i_b) ? i_a : i_b;
            ALU_MIN:    o_grade = (i_a < i_b) ? i_a : i_b;
            ALU_PSUM:   o_grade = psum;
            ALU_PROD:   o_grade = ab;
            ALU_COMPL:  o_grade = GRADE_ONE - i_a;
            default:    o_grade = i_a;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/fuzzy_set_merge_ops_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Fuzzy set merge core. Words with func 0 or 1 append a (key, grade) pair to
// set A or B in one cycle each (grades above one are saturated, pairs past
// the 32-entry capacity are dropped). A word with func 2 runs a merge under
// set_op and streams the result pairs, the last one flagged; an empty result
// gives one word with empty_res set. During a run the input is not ready.
// Each merge step is sequenced over the registered read of both stores and a
// shared grade unit whose multiplier output is registered: a step that drops
// its key passes FETCH and CMP, a step that yields a pair goes on through MUL
// and COMB, and the run ends with the final head check in FETCH and a flush of
// the final word in FIN; COMB and FIN wait while the output is stalled.
// Both stores are empty again when the input turns ready.
module fuzzy_set_merge_ops_core
    import fsmo_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input words
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_func,
    input  wire logic [PORT_KEY_W-1:0] i_key,
    input  wire logic [GRADE_W-1:0]    i_grade,
    // result words
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [PORT_KEY_W-1:0]      o_out_key,
    output logic [GRADE_W-1:0]         o_out_grade,
    output logic                       o_last,
    output logic                       o_empty_res,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam logic REG_SET_OP = 1'b0;

    t_state    r_state, n_state;
    logic [2:0] r_set_op;
    t_cnt      r_cnt_a, r_cnt_b;
    t_cnt      r_ia, r_ib;

    t_key      r_key;
    t_grade    r_ga, r_gb;
    t_alu_op   r_alu_op;

    logic      r_hold_v;
    t_key      r_hold_key;
    t_grade    r_hold_grade;

    logic      r_out_v;
    logic [PORT_KEY_W-1:0] r_out_key;
    t_grade    r_out_grade;
    logic      r_out_last;
    logic      r_out_empty;

    t_entry    rd_a, rd_b, wr_entry;
    t_grade    alu_grade;
    t_func     func;
    logic      in_acc, we_a, we_b, cfg_we;
    logic      a_ok, b_ok, is_compl, keep_single, run_done;
    logic      take_a, take_b, emit;
    t_alu_op   alu_sel;
    logic      out_free, push_ok;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_SET_OP);
    assign prdata = (paddr[2] == REG_SET_OP) ? {29'd0, r_set_op} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_op <= SET_OP_UNION;
        end else if (cfg_we) begin
            r_set_op <= pwdata[2:0];
        end
    end

    // Input decode and loads
    assign func       = t_func'(i_func);
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign we_a       = in_acc && (func == FUNC_LOAD_A) && (r_cnt_a < t_cnt'(SET_DEPTH));
    assign we_b       = in_acc && (func == FUNC_LOAD_B) && (r_cnt_b < t_cnt'(SET_DEPTH));
    assign wr_entry   = '{key: key_from_port(i_key), grade: sat_grade(i_grade)};

    fsmo_set_store u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[IDX_W-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (r_ia[IDX_W-1:0]),
        .o_rdata (rd_a)
    );

    fsmo_set_store u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[IDX_W-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (r_ib[IDX_W-1:0]),
        .o_rdata (rd_b)
    );

    fsmo_grade_alu u_alu (
        .i_clk   (i_clk),
        .i_a     (r_ga),
        .i_b     (r_gb),
        .i_op    (r_alu_op),
        .o_grade (alu_grade)
    );

    // Merge head status
    assign a_ok        = r_ia < r_cnt_a;
    assign b_ok        = r_ib < r_cnt_b;
    assign is_compl    = (r_set_op == SET_OP_COMPL);
    assign keep_single = !((r_set_op == SET_OP_INTER) || (r_set_op == SET_OP_PROD));
    assign run_done    = is_compl ? !a_ok : (!a_ok && !b_ok);
    assign out_free    = !r_out_v || i_out_ready;
    assign push_ok     = !r_hold_v || out_free;

    // Pick the head to take and the grade operation
    always_comb begin
        take_a  = 1'b0;
        take_b  = 1'b0;
        alu_sel = ALU_PASS_A;
        priority if (is_compl) begin
            take_a  = 1'b1;
            alu_sel = ALU_COMPL;
        end else if (!a_ok) begin
            take_b  = 1'b1;
            alu_sel = ALU_PASS_B;
        end else if (!b_ok) begin
            take_a  = 1'b1;
        end else if (rd_a.key == rd_b.key) begin
            take_a  = 1'b1;
            take_b  = 1'b1;
            alu_sel = alu_for_op(r_set_op);
        end else if (rd_a.key < rd_b.key) begin
            take_a  = 1'b1;
        end else begin
            take_b  = 1'b1;
            alu_sel = ALU_PASS_B;
        end
        emit = is_compl || (take_a && take_b) || keep_single;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_acc && (func == FUNC_RUN)) n_state = ST_FETCH;
            ST_FETCH: n_state = run_done ? ST_FIN : ST_CMP;
            ST_CMP:   n_state = emit ? ST_MUL : ST_FETCH;
            ST_MUL:   n_state = ST_COMB;
            ST_COMB:  if (push_ok) n_state = ST_FETCH;
            ST_FIN:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Fill counts and head pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_ia    <= '0;
            r_ib    <= '0;
        end else begin
            if (we_a) r_cnt_a <= r_cnt_a + t_cnt'(1);
            if (we_b) r_cnt_b <= r_cnt_b + t_cnt'(1);
            if (r_state == ST_IDLE) begin
                r_ia <= '0;
                r_ib <= '0;
            end else if (r_state == ST_CMP) begin
                r_ia <= r_ia + t_cnt'(take_a);
                r_ib <= r_ib + t_cnt'(take_b);
            end
            if ((r_state == ST_FIN) && out_free) begin
                r_cnt_a <= '0;
                r_cnt_b <= '0;
            end
        end
    end

    // Latch operands for the grade unit
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CMP) begin
            r_key    <= take_a ? rd_a.key : rd_b.key;
            r_ga     <= rd_a.grade;
            r_gb     <= rd_b.grade;
            r_alu_op <= alu_sel;
        end
    end

    // Hold the newest result until the next one shows whether it is the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
        end else if ((r_state == ST_COMB) && push_ok) begin
            r_hold_v <= 1'b1;
        end else if ((r_state == ST_FIN) && out_free) begin
            r_hold_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_COMB) && push_ok) begin
            r_hold_key   <= r_key;
            r_hold_grade <= alu_grade;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (((r_state == ST_COMB) && push_ok && r_hold_v) ||
                     ((r_state == ST_FIN) && out_free)) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_COMB) && push_ok && r_hold_v) begin
            r_out_key   <= key_to_port(r_hold_key);
            r_out_grade <= r_hold_grade;
            r_out_last  <= 1'b0;
            r_out_empty <= 1'b0;
        end else if ((r_state == ST_FIN) && out_free) begin
            r_out_key   <= r_hold_v ? key_to_port(r_hold_key) : '0;
            r_out_grade <= r_hold_v ? r_hold_grade : '0;
            r_out_last  <= 1'b1;
            r_out_empty <= !r_hold_v;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_key   = r_out_key;
    assign o_out_grade = r_out_grade;
    assign o_last      = r_out_last;
    assign o_empty_res = r_out_empty;

endmodule

`default_nettype wire

// File: rtl/core/fsmo_core_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "fuzzy_set_merge_ops_core_macros.svh"

module fsmo_core_checker
    import fsmo_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_in_ready,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [PORT_KEY_W-1:0] o_out_key,
    input wire logic [GRADE_W-1:0]    o_out_grade,
    input wire logic                  o_last,
    input wire logic                  o_empty_res
);

    // A stalled result word holds
    `FSMO_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_grade) && $stable(o_last), "result word dropped while stalled")

    // An empty result is the last word of its run, with zero key and grade
    `FSMO_ASSERT(a_empty_last, i_clk, i_rst_n, o_out_valid && o_empty_res |-> o_last && (o_out_key == '0) && (o_out_grade == '0), "empty result not a lone zero word")

    // Grades never exceed one
    `FSMO_ASSERT(a_grade_range, i_clk, i_rst_n, o_out_valid |-> (o_out_grade <= GRADE_ONE), "result grade above one")

    // The input is closed while a run streams results short of the last word
    `FSMO_ASSERT(a_run_busy, i_clk, i_rst_n, o_out_valid && !o_last |-> !o_in_ready, "input open during a run")

    // Reset leaves the core idle with nothing to deliver
    `FSMO_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> o_in_ready && !o_out_valid, "core not idle after reset")

endmodule

bind fuzzy_set_merge_ops_core fsmo_core_checker u_fsmo_core_checker (.*);

`default_nettype wire
